FILE: src/gts_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and token kinds for the grammar token scanner.
package gts_pkg;

    localparam int OUT_W       = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [3:0] {
        TK_EOF     = 4'd0,
        TK_IDENT   = 4'd1,
        TK_INT     = 4'd2,
        TK_FLOAT   = 4'd3,
        TK_CHAR    = 4'd4,
        TK_STRING  = 4'd5,
        TK_LBRACK  = 4'd6,
        TK_RBRACK  = 4'd7,
        TK_SEMI    = 4'd8,
        TK_BAR     = 4'd9,
        TK_ARROW   = 4'd10,
        TK_UNKNOWN = 4'd11
    } tok_kind_t;

    // Coarse class of a byte, chosen by the front end
    typedef enum logic [3:0] {
        CL_WS,
        CL_IDENT,
        CL_DIGIT,
        CL_QUOTE,
        CL_MINUS,
        CL_LBRACK,
        CL_RBRACK,
        CL_SEMI,
        CL_BAR,
        CL_OTHER
    } char_class_t;

    typedef struct packed {
        logic        eot;
        char_class_t cls;
        logic        is_zero;
        logic        is_x;
        logic        is_dot;
        logic        is_hex_upper;
        logic        is_gt;
        logic        is_bslash;
        logic        is_crlf;
        logic        is_squote;
        logic        is_dquote;
    } item_t;

    typedef struct packed {
        tok_kind_t          kind;
        logic [OUT_W-1:0]   start;
        logic [OUT_W-1:0]   length;
    } tok_t;

    typedef enum logic [6:0] {
        MODE_IDLE  = 7'b0000001,
        MODE_IDENT = 7'b0000010,
        MODE_ZERO  = 7'b0000100,
        MODE_DEC   = 7'b0001000,
        MODE_HEX   = 7'b0010000,
        MODE_QUOTE = 7'b0100000,
        MODE_MINUS = 7'b1000000
    } scan_mode_t;

endpackage

FILE: src/gts_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for text bytes in and tokens out.
interface gts_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface gts_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [23:0] token_start;
    logic [23:0] token_length;
    logic        last;

    modport source (output valid, token_kind, token_start, token_length, last, input ready);
    modport sink   (input valid, token_kind, token_start, token_length, last, output ready);
endinterface

FILE: src/gts_front.sv
`timescale 1ns / 1ps
// Front end: accepts text bytes and classifies them for the scanner.
module gts_front import gts_pkg::*;
(
    gts_text_if.sink   text,
    output logic       push_valid,
    input  logic       push_ready,
    output item_t      push_item
);

    logic [7:0] b;

    assign b          = text.text_byte;
    assign text.ready = push_ready;
    assign push_valid = text.valid;

    always_comb
    begin
        push_item              = '0;
        push_item.eot          = text.end_of_text;
        push_item.is_zero      = (b == CH_ZERO);
        push_item.is_x         = (b == CH_X);
        push_item.is_dot       = (b == CH_DOT);
        push_item.is_hex_upper = b inside {[8'h41:8'h46]};
        push_item.is_gt        = (b == CH_GT);
        push_item.is_bslash    = (b == CH_BSLASH);
        push_item.is_crlf      = (b == CH_CR) || (b == CH_LF);
        push_item.is_squote    = (b == CH_SQUOTE);
        push_item.is_dquote    = (b == CH_DQUOTE);

        if (b inside {8'h20, [8'h09:8'h0D]})
            push_item.cls = CL_WS;
        else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER})
            push_item.cls = CL_IDENT;
        else if (b inside {[8'h30:8'h39]})
            push_item.cls = CL_DIGIT;
        else if (b inside {CH_SQUOTE, CH_DQUOTE})
            push_item.cls = CL_QUOTE;
        else if (b == CH_MINUS)
            push_item.cls = CL_MINUS;
        else if (b == CH_LBRACK)
            push_item.cls = CL_LBRACK;
        else if (b == CH_RBRACK)
            push_item.cls = CL_RBRACK;
        else if (b == CH_SEMI)
            push_item.cls = CL_SEMI;
        else if (b == CH_BAR)
            push_item.cls = CL_BAR;
        else
            push_item.cls = CL_OTHER;
    end

endmodule

FILE: src/gts_queue.sv
`timescale 1ns / 1ps
// Small FIFO of classified items between front end and scanner.
module gts_queue import gts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr, do_rd;

    assign wr_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

FILE: src/gts_back.sv
`timescale 1ns / 1ps
// Back end: scanner state, token building and the output register.
module gts_back import gts_pkg::*;
#(
    parameter int OFFSET_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         rd_valid,
    output logic         rd_ready,
    input  item_t        rd_item,
    gts_token_if.source  tokens
);

    typedef logic [OFFSET_BITS-1:0] off_t;

    scan_mode_t mode_reg, mode_next;
    off_t       pos_reg, pos_next;
    off_t       pstart_reg, pstart_next;
    off_t       plen_reg, plen_next;
    logic       point_reg, point_next;
    logic       bslash_reg, bslash_next;
    logic       oquote_reg, oquote_next;
    logic       sub_reg, sub_next;

    logic       ovalid_reg;
    tok_t       otok_reg;
    logic       olast_reg;

    logic       a_v, b_v, consumed, closing;
    tok_t       ta, tb, r0;
    logic       load, pop, load_tok, tok_last;
    tok_t       tok_sel;

    function automatic tok_kind_t pend_kind(scan_mode_t m, logic sp, logic oq);
        tok_kind_t k;
        case (m)
            MODE_IDENT:                     k = TK_IDENT;
            MODE_ZERO, MODE_DEC, MODE_HEX:  k = sp ? TK_FLOAT : TK_INT;
            MODE_QUOTE:                     k = oq ? TK_STRING : TK_CHAR;
            default:                        k = TK_UNKNOWN;
        endcase
        return k;
    endfunction

    // One scan step: up to two tokens (pending flush first, then the fresh one)
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg + 1'b1;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        point_next  = point_reg;
        bslash_next = bslash_reg;
        oquote_next = oquote_reg;
        a_v         = 1'b0;
        b_v         = 1'b0;
        consumed    = 1'b0;
        closing     = 1'b0;
        ta          = '{kind: pend_kind(mode_reg, point_reg, oquote_reg),
                        start: OUT_W'(pstart_reg), length: OUT_W'(plen_reg)};
        tb          = '{kind: TK_EOF, start: OUT_W'(pos_reg), length: '0};

        if (rd_item.eot)
        begin
            a_v         = (mode_reg != MODE_IDLE);
            b_v         = 1'b1;
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            plen_next   = '0;
            point_next  = 1'b0;
            bslash_next = 1'b0;
            oquote_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (rd_item.cls == CL_IDENT || rd_item.cls == CL_DIGIT)
                    begin
                        plen_next = plen_reg + 1'b1;
                        consumed  = 1'b1;
                    end
                end
                MODE_ZERO, MODE_DEC, MODE_HEX:
                begin
                    if (mode_reg == MODE_ZERO && rd_item.is_x)
                    begin
                        plen_next = plen_reg + 1'b1;
                        mode_next = MODE_HEX;
                        consumed  = 1'b1;
                    end
                    else
                    begin
                        if (mode_reg == MODE_ZERO)
                            mode_next = MODE_DEC;
                        if (rd_item.is_dot)
                        begin
                            point_next = 1'b1;
                            plen_next  = plen_reg + 1'b1;
                            consumed   = 1'b1;
                        end
                        else if (rd_item.cls == CL_DIGIT ||
                                 (mode_reg == MODE_HEX && rd_item.is_hex_upper))
                        begin
                            plen_next = plen_reg + 1'b1;
                            consumed  = 1'b1;
                        end
                    end
                end
                MODE_QUOTE:
                begin
                    consumed  = 1'b1;
                    plen_next = plen_reg + 1'b1;
                    closing   = rd_item.is_crlf ||
                                ((oquote_reg ? rd_item.is_dquote : rd_item.is_squote) &&
                                 !bslash_reg);
                    if (closing)
                    begin
                        a_v         = 1'b1;
                        ta.length   = OUT_W'(plen_next);
                        mode_next   = MODE_IDLE;
                        bslash_next = 1'b0;
                    end
                    else
                        bslash_next = rd_item.is_bslash;
                end
                MODE_MINUS:
                begin
                    if (rd_item.is_gt)
                    begin
                        a_v       = 1'b1;
                        ta.kind   = TK_ARROW;
                        ta.length = OUT_W'(2);
                        mode_next = MODE_IDLE;
                        consumed  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (!consumed)
            begin
                a_v       = (mode_reg != MODE_IDLE);
                mode_next = MODE_IDLE;
                tb.length = OUT_W'(1);
                case (rd_item.cls)
                    CL_WS:
                    begin
                    end
                    CL_IDENT, CL_DIGIT, CL_QUOTE, CL_MINUS:
                    begin
                        pstart_next = pos_reg;
                        plen_next   = off_t'(1);
                        point_next  = 1'b0;
                        bslash_next = 1'b0;
                        if (rd_item.cls == CL_IDENT)
                            mode_next = MODE_IDENT;
                        else if (rd_item.cls == CL_DIGIT)
                            mode_next = rd_item.is_zero ? MODE_ZERO : MODE_DEC;
                        else if (rd_item.cls == CL_QUOTE)
                        begin
                            mode_next   = MODE_QUOTE;
                            oquote_next = rd_item.is_dquote;
                        end
                        else
                            mode_next = MODE_MINUS;
                    end
                    CL_LBRACK: begin b_v = 1'b1; tb.kind = TK_LBRACK;  end
                    CL_RBRACK: begin b_v = 1'b1; tb.kind = TK_RBRACK;  end
                    CL_SEMI:   begin b_v = 1'b1; tb.kind = TK_SEMI;    end
                    CL_BAR:    begin b_v = 1'b1; tb.kind = TK_BAR;     end
                    default:   begin b_v = 1'b1; tb.kind = TK_UNKNOWN; end
                endcase
            end
        end
    end

    assign r0   = a_v ? ta : tb;
    assign load = !ovalid_reg || tokens.ready;

    // Hand tokens to the output register one at a time
    always_comb
    begin
        pop      = 1'b0;
        load_tok = 1'b0;
        tok_last = 1'b1;
        tok_sel  = r0;
        sub_next = sub_reg;
        if (rd_valid)
        begin
            if (!a_v && !b_v)
                pop = 1'b1;
            else if (load)
            begin
                load_tok = 1'b1;
                if (a_v && b_v && !sub_reg)
                begin
                    tok_last = 1'b0;
                    sub_next = 1'b1;
                end
                else
                begin
                    tok_sel  = sub_reg ? tb : r0;
                    pop      = 1'b1;
                    sub_next = 1'b0;
                end
            end
        end
    end

    assign rd_ready            = pop;
    assign tokens.valid        = ovalid_reg;
    assign tokens.token_kind   = otok_reg.kind;
    assign tokens.token_start  = otok_reg.start;
    assign tokens.token_length = otok_reg.length;
    assign tokens.last         = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            point_reg  <= 1'b0;
            bslash_reg <= 1'b0;
            oquote_reg <= 1'b0;
            sub_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
            if (pop)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                point_reg  <= point_next;
                bslash_reg <= bslash_next;
                oquote_reg <= oquote_next;
            end
            if (load_tok)
                ovalid_reg <= 1'b1;
            else if (tokens.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_tok)
        begin
            otok_reg  <= tok_sel;
            olast_reg <= tok_last;
        end
    end

endmodule

FILE: src/grammar_token_scanner_top.sv
`timescale 1ns / 1ps
// Grammar token scanner: text bytes in, kind/start/length tokens out.
// A token's last byte passes the queue before the token is loaded into the output register.
// Throughput: one byte per cycle while tokens are taken; a two-token byte holds the scanner
// until both are loaded, as the single output register carries one token per transfer.
// A four-entry queue lets intake run on while the token sink stalls, until the queue fills.
// Reset (rst_n, asynchronous, active low) empties queue and output; scanner idle at zero.
module grammar_token_scanner_top import gts_pkg::*;
#(
    parameter int OFFSET_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    gts_text_if.sink     text,
    gts_token_if.source  tokens
);

    // Front end to queue
    logic  push_valid, push_ready;
    item_t push_item;

    // Queue to scanner
    logic  pop_valid, pop_ready;
    item_t pop_item;

    // Classification of each byte happens on the way into the queue
    gts_front u_front (
        .text       (text),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    gts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    // Scanner holds the mode and offsets; an item leaves the queue once all its
    // tokens are in the output register
    gts_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item),
        .tokens   (tokens)
    );

endmodule

FILE: tb/tb_grammar_token_scanner_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the grammar token scanner: directed and random text streams.
module tb_grammar_token_scanner_top;
    import gts_pkg::*;

    // Offset width of the scanner under test; positions wrap at this width
    localparam int OFFSET_BITS = 24;

    // Whitespace, letter and other codes that the package does not name
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Stimulus shaping
    localparam int TEXT_ITEMS = 1750;
    localparam int HOLD_AT    = 600;   // receiver holds off here, sender keeps going
    localparam int HOLD_RUN   = 60;    // burst length without gaps during the hold-off
    localparam int PAUSE_AT   = 1200;  // sender waits for the token stream to drain here
    localparam int HOLD_LEN   = 64;    // receiver hold-off in cycles

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    typedef struct {
        tok_kind_t          kind;
        logic [OUT_W-1:0]   start;
        logic [OUT_W-1:0]   length;
        logic               last;
    } token_rec_t;

    // Tracks the lexer state byte by byte and holds the tokens still due from the block
    class lexer_tracker;
        scan_mode_t              mode;
        logic [OFFSET_BITS-1:0]  pos;
        logic [OFFSET_BITS-1:0]  tok_start;
        logic [OFFSET_BITS-1:0]  tok_len;
        bit                      seen_point;
        bit                      prior_bs;
        bit                      dquote;
        token_rec_t              tokens_due[$];
        token_rec_t              step_toks[$];
        int                      errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            mode       = MODE_IDLE;
            pos        = '0;
            tok_start  = '0;
            tok_len    = '0;
            seen_point = 0;
            prior_bs   = 0;
            dquote     = 0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_ident_head(logic [7:0] c);
            return c == CH_UNDER || (c >= CH_UA && c <= 8'h5A) || (c >= CH_LA && c <= 8'h7A);
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT ||
                   c == CH_CR || c == CH_LF;
        endfunction

        function void emit_tok(tok_kind_t kind, logic [OFFSET_BITS-1:0] st,
                               logic [OFFSET_BITS-1:0] len);
            token_rec_t t;
            t.kind   = kind;
            t.start  = st[OUT_W-1:0];
            t.length = len[OUT_W-1:0];
            t.last   = 0;
            step_toks.push_back(t);
        endfunction

        function void open_tok(scan_mode_t m);
            mode       = m;
            tok_start  = pos;
            tok_len    = OFFSET_BITS'(1);
            seen_point = 0;
            prior_bs   = 0;
        endfunction

        function void grow_tok();
            tok_len = tok_len + 1'b1;
        endfunction

        function void flush_pending();
            tok_kind_t kind;
            case (mode)
                MODE_IDENT:                    kind = TK_IDENT;
                MODE_ZERO, MODE_DEC, MODE_HEX: kind = seen_point ? TK_FLOAT : TK_INT;
                MODE_QUOTE:                    kind = dquote ? TK_STRING : TK_CHAR;
                MODE_MINUS:                    kind = TK_UNKNOWN;
                default:                       return;
            endcase
            emit_tok(kind, tok_start, tok_len);
            mode = MODE_IDLE;
        endfunction

        // Byte seen with nothing pending
        function void scan_new(logic [7:0] c);
            if (is_ws(c))
                return;
            if (is_ident_head(c))
                open_tok(MODE_IDENT);
            else if (is_digit(c))
                open_tok(c == CH_ZERO ? MODE_ZERO : MODE_DEC);
            else if (c == CH_SQUOTE || c == CH_DQUOTE)
            begin
                open_tok(MODE_QUOTE);
                dquote = (c == CH_DQUOTE);
            end
            else if (c == CH_MINUS)
                open_tok(MODE_MINUS);
            else if (c == CH_LBRACK)
                emit_tok(TK_LBRACK, pos, OFFSET_BITS'(1));
            else if (c == CH_RBRACK)
                emit_tok(TK_RBRACK, pos, OFFSET_BITS'(1));
            else if (c == CH_SEMI)
                emit_tok(TK_SEMI, pos, OFFSET_BITS'(1));
            else if (c == CH_BAR)
                emit_tok(TK_BAR, pos, OFFSET_BITS'(1));
            else
                emit_tok(TK_UNKNOWN, pos, OFFSET_BITS'(1));
        endfunction

        function void take_byte(logic [7:0] c, logic eot);
            bit taken;
            taken = 0;
            step_toks.delete();
            if (eot)
            begin
                flush_pending();
                emit_tok(TK_EOF, pos, '0);
                clear_state();
            end
            else
            begin
                case (mode)
                    MODE_IDENT:
                        if (is_ident_head(c) || is_digit(c))
                        begin
                            grow_tok();
                            taken = 1;
                        end
                    MODE_ZERO, MODE_DEC, MODE_HEX:
                        if (mode == MODE_ZERO && c == CH_X)
                        begin
                            grow_tok();
                            mode  = MODE_HEX;
                            taken = 1;
                        end
                        else
                        begin
                            if (mode == MODE_ZERO)
                                mode = MODE_DEC;
                            if (c == CH_DOT)
                            begin
                                seen_point = 1;
                                grow_tok();
                                taken = 1;
                            end
                            else if (is_digit(c) ||
                                     (mode == MODE_HEX && c >= CH_UA && c <= CH_UF))
                            begin
                                grow_tok();
                                taken = 1;
                            end
                        end
                    MODE_QUOTE:
                    begin
                        taken = 1;
                        grow_tok();
                        // escaped quote does not close; line break always does
                        if (c == CH_CR || c == CH_LF ||
                            (c == (dquote ? CH_DQUOTE : CH_SQUOTE) && !prior_bs))
                        begin
                            flush_pending();
                            prior_bs = 0;
                        end
                        else
                            prior_bs = (c == CH_BSLASH);
                    end
                    MODE_MINUS:
                        if (c == CH_GT)
                        begin
                            emit_tok(TK_ARROW, tok_start, OFFSET_BITS'(2));
                            mode  = MODE_IDLE;
                            taken = 1;
                        end
                    default: ;
                endcase
                if (!taken)
                begin
                    flush_pending();
                    scan_new(c);
                end
                pos = pos + 1'b1;
            end
            if (step_toks.size() > 0)
                step_toks[step_toks.size()-1].last = 1;
            foreach (step_toks[i])
                tokens_due.push_back(step_toks[i]);
        endfunction

        function void match_token(logic [3:0] kind, logic [OUT_W-1:0] st,
                                  logic [OUT_W-1:0] len, logic lst);
            token_rec_t t;
            if (tokens_due.size() == 0)
            begin
                $display("%0t: token with none due: kind %0d start %0d length %0d last %0d",
                         $time, kind, st, len, lst);
                errors++;
                return;
            end
            t = tokens_due.pop_front();
            if (kind !== t.kind)
            begin
                $display("%0t: kind mismatch: expected %0d actual %0d", $time, t.kind, kind);
                errors++;
            end
            if (st !== t.start)
            begin
                $display("%0t: start mismatch: expected %0d actual %0d", $time, t.start, st);
                errors++;
            end
            if (len !== t.length)
            begin
                $display("%0t: length mismatch: expected %0d actual %0d", $time, t.length, len);
                errors++;
            end
            if (lst !== t.last)
            begin
                $display("%0t: last mismatch: expected %0d actual %0d", $time, t.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gts_text_if  text_ch ();
    gts_token_if token_ch ();

    grammar_token_scanner_top #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (token_ch)
    );

    lexer_tracker tracker = new();
    text_item_t   text_seq[$];
    bit           hold_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("grammar_token_scanner_top test failed");
        $finish;
    end

    // Both transfers are observed on the rising edge; inputs only move on the falling edge.
    // Bytes are noted before tokens are checked, though a token never leaves in the
    // same cycle as its byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
                tracker.take_byte(text_ch.text_byte, text_ch.end_of_text);
            if (token_ch.valid && token_ch.ready)
                tracker.match_token(token_ch.token_kind, token_ch.token_start,
                                    token_ch.token_length, token_ch.last);
        end
    end

    // Token sink: picks its own stall pattern every so often; a hold-off request from
    // the stimulus side makes it refuse every token for a hold-off whose length HOLD_LEN sets.
    initial
    begin
        int hold_cnt;
        int style;
        int cyc;
        hold_cnt = 0;
        style    = 0;
        cyc      = 0;
        token_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 150 == 0)
                style = $urandom_range(0, 3);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                token_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold_cnt = HOLD_LEN - 1;
                token_ch.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0:       token_ch.ready <= 1'b1;
                    1:       token_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       token_ch.ready <= ($urandom_range(0, 1) != 0);
                    default: token_ch.ready <= ((cyc % 7) < 4);
                endcase
            end
        end
    end

    function automatic void push_item(logic [7:0] c, logic eot);
        text_item_t it;
        it.ch  = c;
        it.eot = eot;
        text_seq.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] ident_char(bit head);
        int r;
        r = $urandom_range(0, head ? 52 : 62);
        if (r < 26)
            return CH_UA + 8'(r);
        else if (r < 52)
            return CH_LA + 8'(r - 26);
        else if (r == 52)
            return CH_UNDER;
        return CH_ZERO + 8'(r - 53);
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // One lexically plausible fragment, or a stray byte, or an end-of-text mark, at times followed by whitespace
    function automatic void add_fragment();
        int         sel;
        int         n;
        logic [7:0] q;
        sel = $urandom_range(0, 99);
        if (sel < 20)
        begin
            push_item(ident_char(1), 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) push_item(ident_char(0), 1'b0);
        end
        else if (sel < 35)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                // hex: decimal and upper-case digits mostly, a lower-case or a dot now and then
                push_item(CH_ZERO, 1'b0);
                push_item(CH_X, 1'b0);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    case ($urandom_range(0, 9))
                        0:       push_item(CH_LA + 8'($urandom_range(0, 5)), 1'b0);
                        1:       push_item(CH_DOT, 1'b0);
                        2, 3, 4: push_item(CH_UA + 8'($urandom_range(0, 5)), 1'b0);
                        default: push_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                    endcase
                end
            end
            else
            begin
                push_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                n = $urandom_range(0, 6);
                repeat (n)
                    push_item(($urandom_range(0, 5) == 0) ? CH_DOT
                                                          : CH_ZERO + 8'($urandom_range(0, 9)),
                              1'b0);
            end
        end
        else if (sel < 50)
        begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            push_item(q, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0:       push_item(CH_BSLASH, 1'b0);
                    1:       push_item(q, 1'b0);
                    2:       push_item(8'($urandom_range(0, 255)), 1'b0);
                    default: push_item(8'($urandom_range(CH_SPACE, CH_TILDE)), 1'b0);
                endcase
            end
            case ($urandom_range(0, 8))
                6:       push_item(CH_CR, 1'b0);
                7:       push_item(CH_LF, 1'b0);
                8:       ;  // left open
                default: push_item(q, 1'b0);
            endcase
        end
        else if (sel < 60)
        begin
            case ($urandom_range(0, 3))
                0:       push_item(CH_LBRACK, 1'b0);
                1:       push_item(CH_RBRACK, 1'b0);
                2:       push_item(CH_SEMI, 1'b0);
                default: push_item(CH_BAR, 1'b0);
            endcase
        end
        else if (sel < 67)
        begin
            push_item(CH_MINUS, 1'b0);
            if ($urandom_range(0, 2) != 0)
                push_item(CH_GT, 1'b0);
        end
        else if (sel < 80)
        begin
            n = $urandom_range(1, 3);
            repeat (n) push_item(ws_char(), 1'b0);
        end
        else if (sel < 95)
            push_item(8'($urandom_range(0, 255)), 1'b0);
        else
            push_item(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 9) < 4)
            push_item(ws_char(), 1'b0);
    endfunction

    // Offer one byte and hold it until the input queue takes it; returns on the falling edge
    task automatic send_text(text_item_t it);
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= it.ch;
        text_ch.end_of_text <= it.eot;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int burst_left;
        int no_gap_left;
        int gap;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = '0;
        text_ch.end_of_text = 1'b0;
        hold_req            = 0;
        rst_n               = 1'b0;

        // Directed opening: identifier with digits, hex ended by lower case, float
        // ended by a quote, escaped quote in a char literal, string closed by LF,
        // every single-byte token, arrow, lone minus followed by a zero byte, and a
        // string left open at end of text (two tokens from the mark).
        push_text("a_9 0xFa 1.2'\\''\"s\n[];|->-");
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CH_DQUOTE, 1'b0);
        push_item(8'hFF, 1'b1);
        // end of text with nothing pending
        push_item(8'h00, 1'b1);

        while (text_seq.size() < TEXT_ITEMS)
            add_fragment();
        push_item(8'($urandom_range(0, 255)), 1'b1);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        burst_left  = 0;
        no_gap_left = 0;
        foreach (text_seq[i])
        begin
            if (i == HOLD_AT)
            begin
                // sink blocks; keep offering so the input queue fills and stalls intake
                hold_req    = 1;
                no_gap_left = HOLD_RUN;
            end
            if (i == PAUSE_AT)
            begin
                text_ch.valid <= 1'b0;
                while (tracker.pending() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            // a stretch of back-to-back transfers between 300 and 500
            if (i >= 300 && i < 500)
                no_gap_left = (no_gap_left > 1) ? no_gap_left : 1;
            if (no_gap_left > 0)
                no_gap_left--;
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                gap        = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    text_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            else
                burst_left--;
            send_text(text_seq[i]);
        end
        text_ch.valid <= 1'b0;

        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("grammar_token_scanner_top test passed");
        else
            $display("grammar_token_scanner_top test failed");
        $finish;
    end

endmodule

FILE: grammar_token_scanner_top.f
src/gts_pkg.sv
src/gts_if.sv
src/gts_front.sv
src/gts_queue.sv
src/gts_back.sv
src/grammar_token_scanner_top.sv
tb/tb_grammar_token_scanner_top.sv
